@@ hw/rtl/bops_pkg.sv @@
// ----------------------------------------------------------------------------
// Bit occupancy statistics package
// Shared field widths, request codes and parameter defaults for the
// bit occupancy and popcount histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package bops_pkg;

	// Request and result field widths.
	localparam int REQ_TYPE_W   = 2;
	localparam int PATTERN_W    = 16;
	localparam int STAT_INDEX_W = 6;
	localparam int VALUE_W      = 48;
	localparam int POPCOUNT_W   = 5;
	localparam int LIMIT_W      = 48;

	// Defaults for the top-level parameters.
	localparam int PATTERN_BITS_DEF = 16;
	localparam int COUNT_WIDTH_DEF  = 48;

	// Request codes. The fourth code is unused and changes nothing.
	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_COUNT = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2
	} req_type_t;

endpackage

`default_nettype wire

@@ hw/rtl/bops_req_if.sv @@
// ----------------------------------------------------------------------------
// Bit occupancy statistics request channel
// Valid/ready channel that carries one request to the statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

interface bops_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [bops_pkg::REQ_TYPE_W-1:0]      req_type;
	logic [bops_pkg::PATTERN_W-1:0]       pattern;
	logic [bops_pkg::STAT_INDEX_W-1:0]    stat_index;

	modport source (output valid, req_type, pattern, stat_index, input ready);
	modport sink   (input valid, req_type, pattern, stat_index, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bops_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Bit occupancy statistics response channel
// Valid/ready channel that carries one result out of the statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

interface bops_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [bops_pkg::VALUE_W-1:0]       read_value;
	logic [bops_pkg::POPCOUNT_W-1:0]    pattern_popcount;
	logic                               counted;
	logic                               limit_reached;

	modport source (output valid, read_value, pattern_popcount, counted, limit_reached,
		input ready);
	modport sink   (input valid, read_value, pattern_popcount, counted, limit_reached,
		output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bit_occupancy_popcount_stats.sv @@
// ----------------------------------------------------------------------------
// Bit occupancy and popcount histogram statistics
// Counts set bit positions, popcount bins and a record total over a stream
// of pattern words, with a sample limit, counter read-out and clear.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake          Payload
//   req       in          valid / ready      req_type, pattern, stat_index
//   rsp       out         valid / ready      read_value, pattern_popcount,
//                                            counted, limit_reached
//   cfg       in          cfg_wr_en          cfg_wr_data (sample_limit)
//
// Every request gives exactly one result from the result register. While
// the output flows, a request can be accepted in every cycle: the popcount,
// the saturating increments and the limit compare fit in the one stage
// between the input and result registers, and that same edge updates the
// counters. A stalled output holds the result register; the input register
// fills and then drops ready. Reset clears all counters and the limit.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_occupancy_popcount_stats #(
	parameter int PATTERN_BITS = bops_pkg::PATTERN_BITS_DEF,
	parameter int COUNT_WIDTH  = bops_pkg::COUNT_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	bops_req_if.sink                         req,
	bops_rsp_if.source                       rsp,
	input  wire                              cfg_wr_en,
	input  wire [bops_pkg::LIMIT_W-1:0]      cfg_wr_data
);

	// Number of popcount bins; one for every count from zero to full.
	localparam int NUM_BINS = PATTERN_BITS + 1;
	// Popcount width and the nibble split used to keep the adder chain short.
	localparam int POP_W    = $clog2(PATTERN_BITS + 1);
	localparam int NIB      = (PATTERN_BITS + 3) / 4;
	localparam int PAD_W    = NIB * 4;
	// The pattern field may be narrower than the counted width; the missing
	// high bits count as zero.
	localparam int EXT_W    = (PATTERN_BITS > bops_pkg::PATTERN_W) ?
		PATTERN_BITS : bops_pkg::PATTERN_W;
	// Wide enough to hold every counter index, including the record total.
	localparam int IDX_MAX  = 2 * PATTERN_BITS + 1;
	localparam int IDX_W0   = $clog2(IDX_MAX + 1);
	localparam int IDX_W    = (IDX_W0 > bops_pkg::STAT_INDEX_W) ?
		IDX_W0 : bops_pkg::STAT_INDEX_W;
	// Width of the limit compare.
	localparam int CMP_W    = (COUNT_WIDTH > bops_pkg::LIMIT_W) ?
		COUNT_WIDTH : bops_pkg::LIMIT_W;

	// ------------------------------------------------------------------------
	// Configuration register.
	// ------------------------------------------------------------------------
	logic [bops_pkg::LIMIT_W-1:0] sample_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_limit_q <= '0;
		end else if (cfg_wr_en) begin
			sample_limit_q <= cfg_wr_data;
		end
	end

	// ------------------------------------------------------------------------
	// Input register (stage 1).
	// ------------------------------------------------------------------------
	logic                                 valid_s1;
	logic [bops_pkg::REQ_TYPE_W-1:0]      req_type_s1;
	logic [bops_pkg::PATTERN_W-1:0]       pattern_s1;
	logic [bops_pkg::STAT_INDEX_W-1:0]    stat_index_s1;

	logic                                 valid_s2;
	logic                                 adv_s1;

	// Stage 1 moves on when the result register is empty or being drained.
	assign adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1   <= req.req_type;
			pattern_s1    <= req.pattern;
			stat_index_s1 <= req.stat_index;
		end
	end

	// ------------------------------------------------------------------------
	// Counter state.
	// ------------------------------------------------------------------------
	logic [COUNT_WIDTH-1:0] bit_cnt_q [PATTERN_BITS];
	logic [COUNT_WIDTH-1:0] bin_cnt_q [NUM_BINS];
	logic [COUNT_WIDTH-1:0] total_q;

	logic [COUNT_WIDTH-1:0] bit_cnt_d [PATTERN_BITS];
	logic [COUNT_WIDTH-1:0] bin_cnt_d [NUM_BINS];
	logic [COUNT_WIDTH-1:0] total_d;

	// ------------------------------------------------------------------------
	// Request decode.
	// ------------------------------------------------------------------------
	logic is_count;
	logic is_read;
	logic is_clear;

	always_comb begin
		is_count = 1'b0;
		is_read  = 1'b0;
		is_clear = 1'b0;
		case (bops_pkg::req_type_t'(req_type_s1))
			bops_pkg::REQ_COUNT: begin
				is_count = 1'b1;
			end
			bops_pkg::REQ_READ: begin
				is_read = 1'b1;
			end
			bops_pkg::REQ_CLEAR: begin
				is_clear = 1'b1;
			end
			default: begin
				// The unused code only reports the limit status.
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Popcount: four-bit groups first, then a short sum over the groups.
	// ------------------------------------------------------------------------
	logic [EXT_W-1:0]        pat_ext;
	logic [PATTERN_BITS-1:0] pat_eff;
	logic [PAD_W-1:0]        pat_pad;
	logic [2:0]              nib_cnt [NIB];
	logic [POP_W-1:0]        pop;

	assign pat_ext = EXT_W'(pattern_s1);
	assign pat_eff = pat_ext[PATTERN_BITS-1:0];
	assign pat_pad = PAD_W'(pat_eff);

	always_comb begin
		for (int n = 0; n < NIB; n++) begin
			nib_cnt[n] = {2'b00, pat_pad[4*n]}   + {2'b00, pat_pad[4*n+1]} +
			             {2'b00, pat_pad[4*n+2]} + {2'b00, pat_pad[4*n+3]};
		end
	end

	always_comb begin
		pop = '0;
		for (int n = 0; n < NIB; n++) begin
			pop = pop + POP_W'(nib_cnt[n]);
		end
	end

	// ------------------------------------------------------------------------
	// Limit test before and after the request. Counting stops once the
	// total has reached a nonzero limit; a saturated total still counts here.
	// ------------------------------------------------------------------------
	logic limit_on;
	logic hit_now;
	logic do_count;
	logic hit_after;

	assign limit_on  = (sample_limit_q != '0);
	assign hit_now   = limit_on && (CMP_W'(total_q) >= CMP_W'(sample_limit_q));
	assign do_count  = is_count && !hit_now;
	assign hit_after = limit_on && (CMP_W'(total_d) >= CMP_W'(sample_limit_q));

	// ------------------------------------------------------------------------
	// Next counter values. Each counter holds at all ones.
	// ------------------------------------------------------------------------
	always_comb begin
		for (int b = 0; b < PATTERN_BITS; b++) begin
			if (is_clear) begin
				bit_cnt_d[b] = '0;
			end else if (do_count && pat_eff[b] && (bit_cnt_q[b] != '1)) begin
				bit_cnt_d[b] = bit_cnt_q[b] + 1'b1;
			end else begin
				bit_cnt_d[b] = bit_cnt_q[b];
			end
		end
		for (int i = 0; i < NUM_BINS; i++) begin
			if (is_clear) begin
				bin_cnt_d[i] = '0;
			end else if (do_count && (pop == POP_W'(i)) && (bin_cnt_q[i] != '1)) begin
				bin_cnt_d[i] = bin_cnt_q[i] + 1'b1;
			end else begin
				bin_cnt_d[i] = bin_cnt_q[i];
			end
		end
		if (is_clear) begin
			total_d = '0;
		end else if (do_count && (total_q != '1)) begin
			total_d = total_q + 1'b1;
		end else begin
			total_d = total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < PATTERN_BITS; b++) begin
				bit_cnt_q[b] <= '0;
			end
			for (int i = 0; i < NUM_BINS; i++) begin
				bin_cnt_q[i] <= '0;
			end
			total_q <= '0;
		end else if (adv_s1) begin
			bit_cnt_q <= bit_cnt_d;
			bin_cnt_q <= bin_cnt_d;
			total_q   <= total_d;
		end
	end

	// ------------------------------------------------------------------------
	// Counter read-out. Bit counts come first, then the bins, then the
	// total; any index past the total reads as zero.
	// ------------------------------------------------------------------------
	logic [IDX_W-1:0]       idx;
	logic [COUNT_WIDTH-1:0] read_cnt;

	assign idx = IDX_W'(stat_index_s1);

	always_comb begin
		read_cnt = '0;
		for (int b = 0; b < PATTERN_BITS; b++) begin
			if (idx == IDX_W'(b)) begin
				read_cnt = read_cnt | bit_cnt_q[b];
			end
		end
		for (int i = 0; i < NUM_BINS; i++) begin
			if (idx == IDX_W'(PATTERN_BITS + i)) begin
				read_cnt = read_cnt | bin_cnt_q[i];
			end
		end
		if (idx == IDX_W'(IDX_MAX)) begin
			read_cnt = read_cnt | total_q;
		end
	end

	// ------------------------------------------------------------------------
	// Result register (stage 2).
	// ------------------------------------------------------------------------
	logic [bops_pkg::VALUE_W-1:0]    read_value_s2;
	logic [bops_pkg::POPCOUNT_W-1:0] popcount_s2;
	logic                            counted_s2;
	logic                            limit_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			read_value_s2 <= is_read ? bops_pkg::VALUE_W'(read_cnt) : '0;
			popcount_s2   <= is_count ? bops_pkg::POPCOUNT_W'(pop) : '0;
			counted_s2    <= do_count;
			limit_s2      <= hit_after;
		end
	end

	assign rsp.valid            = valid_s2;
	assign rsp.read_value       = read_value_s2;
	assign rsp.pattern_popcount = popcount_s2;
	assign rsp.counted          = counted_s2;
	assign rsp.limit_reached    = limit_s2;

`ifndef SYNTH
	// A clear request leaves the record total at zero.
	a_clear_zeroes_total: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && is_clear) |=> (total_q == '0))
		else $error("record total not zero after a clear request");

	// A counted record never carries read data.
	a_counted_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.counted) |-> (rsp.read_value == '0))
		else $error("counted result carries a read value");

	// The input side only stalls when both registers are full and the
	// output is stalled.
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && valid_s2 && !rsp.ready))
		else $error("request channel stalled without an output stall");

	// A counted record follows a total that was below the limit.
	a_count_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && do_count && limit_on) |->
		(CMP_W'(total_q) < CMP_W'(sample_limit_q)))
		else $error("record counted with the limit already reached");
`endif

endmodule

`default_nettype wire

@@ tb/bit_occupancy_popcount_stats_test.sv @@
// ----------------------------------------------------------------------------
// Bit occupancy statistics regression
// Drives count, read, clear and unused requests into the histogram block.
// Random request gaps and result stalls are applied, each switched off in
// some phases. Several sample limit settings are used, the extremes
// among them. Every result is checked, field by field and in order, against
// a predictor that keeps its own copy of the counters.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_occupancy_popcount_stats_test;
	timeunit 1ns;
	timeprecision 1ps;

	// The fourth request code has no name in the package. The block must ignore it.
	localparam logic [bops_pkg::REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

	// Counter layout as seen through stat_index.
	localparam int BIN_BASE    = bops_pkg::PATTERN_W;
	localparam int TOTAL_INDEX = bops_pkg::PATTERN_W + bops_pkg::PATTERN_W + 1;

	// The block holds at most two requests, so settling after the drain is
	// enough before the limit register is rewritten.
	localparam int SETTLE_CYCLES = 4;
	// This is the number of cycles in a row with no handshake on either channel.
	localparam int STALL_LIMIT   = 1000;
	localparam int MAX_GAP       = 10;

	typedef struct packed {
		logic [bops_pkg::REQ_TYPE_W-1:0]   code;
		logic [bops_pkg::PATTERN_W-1:0]    pattern;
		logic [bops_pkg::STAT_INDEX_W-1:0] index;
	} stat_request_t;

	typedef struct packed {
		logic [bops_pkg::VALUE_W-1:0]    read_value;
		logic [bops_pkg::POPCOUNT_W-1:0] pattern_popcount;
		logic                            counted;
		logic                            limit_reached;
	} stat_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [bops_pkg::LIMIT_W-1:0] cfg_wr_data;

	bops_req_if req_ch ();
	bops_rsp_if rsp_ch ();

	bit_occupancy_popcount_stats DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state. It mirrors the counters of the block and the limit.
	// ------------------------------------------------------------------
	logic [bops_pkg::VALUE_W-1:0] bit_hits [bops_pkg::PATTERN_W];
	logic [bops_pkg::VALUE_W-1:0] weight_bins [bops_pkg::PATTERN_W+1];
	logic [bops_pkg::VALUE_W-1:0] record_count;
	logic [bops_pkg::LIMIT_W-1:0] limit_setting;

	// These are the results that the block still owes, oldest first.
	stat_result_t pending_results [$];
	int           mismatches = 0;

	// When a flag is clear, that side runs without idling. Phases toggle the
	// flags so that stretches with no gaps are mixed with heavy idling.
	bit source_gaps_on = 1'b1;
	bit sink_gaps_on   = 1'b1;

	function automatic int pick_gap(input bit enabled);
		return enabled ? int'($urandom_range(0, MAX_GAP)) : 0;
	endfunction

	function automatic logic [bops_pkg::VALUE_W-1:0] bump(
			input logic [bops_pkg::VALUE_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic bit limit_hit();
		return (limit_setting != '0) && (record_count >= limit_setting);
	endfunction

	function automatic void clear_histogram();
		for (int b = 0; b < bops_pkg::PATTERN_W; b++)
			bit_hits[b] = '0;
		for (int w = 0; w <= bops_pkg::PATTERN_W; w++)
			weight_bins[w] = '0;
		record_count = '0;
	endfunction

	// This applies one accepted request to the mirrored counters and returns
	// the result that the block must produce for it.
	function automatic stat_result_t apply_to_histogram(input stat_request_t rq);
		stat_result_t                    res;
		logic [bops_pkg::POPCOUNT_W-1:0] ones;
		res  = '0;
		ones = bops_pkg::POPCOUNT_W'($countones(rq.pattern));
		case (rq.code)
			bops_pkg::REQ_COUNT: begin
				// The popcount is reported even when the limit blocks the record.
				res.pattern_popcount = ones;
				if (!limit_hit()) begin
					for (int b = 0; b < bops_pkg::PATTERN_W; b++)
						if (rq.pattern[b])
							bit_hits[b] = bump(bit_hits[b]);
					weight_bins[ones] = bump(weight_bins[ones]);
					record_count      = bump(record_count);
					res.counted       = 1'b1;
				end
			end
			bops_pkg::REQ_READ: begin
				if (rq.index < BIN_BASE)
					res.read_value = bit_hits[rq.index];
				else if (rq.index < TOTAL_INDEX)
					res.read_value = weight_bins[rq.index - BIN_BASE];
				else if (rq.index == TOTAL_INDEX)
					res.read_value = record_count;
			end
			bops_pkg::REQ_CLEAR: begin
				clear_histogram();
			end
			default: begin
			end
		endcase
		// The limit flag is evaluated after the request has taken effect, for every code.
		res.limit_reached = limit_hit();
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request side. The caller is always just past a rising edge, so
	// each task drives with nonblocking assignments and then waits for edges.
	// ------------------------------------------------------------------
	task automatic send_request(input logic [bops_pkg::REQ_TYPE_W-1:0] code,
			input logic [bops_pkg::PATTERN_W-1:0] pattern,
			input logic [bops_pkg::STAT_INDEX_W-1:0] index);
		stat_request_t rq;
		int            gap;
		rq  = '{code: code, pattern: pattern, index: index};
		gap = pick_gap(source_gaps_on);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= rq.code;
		req_ch.pattern    <= rq.pattern;
		req_ch.stat_index <= rq.index;
		// Values sampled at the edge are the ones from before it. That is
		// what the block itself sees when it accepts the request.
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pending_results.push_back(apply_to_histogram(rq));
	endtask

	// The sender stops and waits until every expected result has come back.
	// It then allows the pipeline to settle.
	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sample_limit(input logic [bops_pkg::LIMIT_W-1:0] value);
		wait_for_drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en     <= 1'b0;
		limit_setting  = value;
	endtask

	// ------------------------------------------------------------------
	// Result side. It stalls at random and checks each accepted result
	// against the oldest expectation.
	// ------------------------------------------------------------------
	initial begin : result_sink
		stat_result_t want;
		int           hold;
		forever begin
			hold = pick_gap(sink_gaps_on);
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (rsp_ch.valid !== 1'b1);
			if (pending_results.size() == 0) begin
				$error("unexpected result: no request is waiting for one");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d", want.read_value,
						rsp_ch.read_value);
					mismatches++;
				end
				if (rsp_ch.pattern_popcount !== want.pattern_popcount) begin
					$error("pattern_popcount: expected %0d, got %0d",
						want.pattern_popcount, rsp_ch.pattern_popcount);
					mismatches++;
				end
				if (rsp_ch.counted !== want.counted) begin
					$error("counted: expected %0d, got %0d", want.counted, rsp_ch.counted);
					mismatches++;
				end
				if (rsp_ch.limit_reached !== want.limit_reached) begin
					$error("limit_reached: expected %0d, got %0d", want.limit_reached,
						rsp_ch.limit_reached);
					mismatches++;
				end
			end
		end
	end

	// The watchdog ends a run that stops making progress on both channels.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("bit_occupancy_popcount_stats regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// This test runs with no limit. It covers the pattern extremes, reads of
	// each region of the index space, the unused code and a clear.
	task automatic test_directed_requests();
		send_request(bops_pkg::REQ_READ, 16'h0000, 6'(TOTAL_INDEX));
		send_request(bops_pkg::REQ_COUNT, 16'h0000, 6'd0);
		send_request(bops_pkg::REQ_COUNT, 16'hFFFF, 6'd63);
		send_request(bops_pkg::REQ_COUNT, 16'h0001, 6'd0);
		send_request(bops_pkg::REQ_COUNT, 16'h8000, 6'd0);
		send_request(bops_pkg::REQ_COUNT, 16'hAAAA, 6'd0);
		send_request(bops_pkg::REQ_READ, 16'hFFFF, 6'd0);
		send_request(bops_pkg::REQ_READ, 16'h0000, 6'd15);
		send_request(bops_pkg::REQ_READ, 16'h0000, 6'(BIN_BASE));
		send_request(bops_pkg::REQ_READ, 16'h0000, 6'(TOTAL_INDEX - 1));
		send_request(bops_pkg::REQ_READ, 16'h0000, 6'(TOTAL_INDEX));
		// Indices past the record total read as zero.
		send_request(bops_pkg::REQ_READ, 16'h0000, 6'(TOTAL_INDEX + 1));
		send_request(bops_pkg::REQ_READ, 16'h0000, 6'd63);
		// The unused code reports neither a popcount nor a value.
		send_request(REQ_UNUSED, 16'hFFFF, 6'(TOTAL_INDEX));
		send_request(bops_pkg::REQ_CLEAR, 16'hFFFF, 6'd0);
		send_request(bops_pkg::REQ_READ, 16'h0000, 6'(TOTAL_INDEX));
		send_request(bops_pkg::REQ_COUNT, 16'h5555, 6'd0);
	endtask

	// A limit of one is reached by the first record. After that, a count
	// request is blocked but still reports its popcount. A clear drops the
	// flag while keeping the limit. The largest limit is then never reached.
	task automatic test_sample_limit_edges();
		write_sample_limit(48'd1);
		send_request(bops_pkg::REQ_CLEAR, 16'h0000, 6'd0);
		send_request(bops_pkg::REQ_COUNT, 16'h00FF, 6'd0);
		send_request(bops_pkg::REQ_COUNT, 16'hFFFF, 6'd0);
		send_request(bops_pkg::REQ_READ, 16'h0000, 6'(TOTAL_INDEX));
		send_request(bops_pkg::REQ_READ, 16'h0000, 6'(TOTAL_INDEX - 1));
		send_request(REQ_UNUSED, 16'h0F0F, 6'd5);
		send_request(bops_pkg::REQ_CLEAR, 16'h0000, 6'd0);
		write_sample_limit('1);
		send_request(bops_pkg::REQ_COUNT, 16'h1234, 6'd0);
		send_request(bops_pkg::REQ_READ, 16'h0000, 6'(TOTAL_INDEX));
	endtask

	// This is one phase of random traffic under a given limit. Count requests
	// dominate, so a small limit is reached, and clears restart the counting.
	task automatic test_random_traffic(input logic [bops_pkg::LIMIT_W-1:0] limit,
			input int items, input int clear_pct, input bit src_gaps, input bit snk_gaps,
			input bit pause_midway);
		logic [bops_pkg::REQ_TYPE_W-1:0]   code;
		logic [bops_pkg::PATTERN_W-1:0]    pattern;
		logic [bops_pkg::STAT_INDEX_W-1:0] index;
		int                                roll;
		int                                bit_pos;
		write_sample_limit(limit);
		source_gaps_on = src_gaps;
		sink_gaps_on   = snk_gaps;
		for (int n = 0; n < items; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 64)
				code = bops_pkg::REQ_COUNT;
			else if (roll < 94 - clear_pct)
				code = bops_pkg::REQ_READ;
			else if (roll < 94)
				code = bops_pkg::REQ_CLEAR;
			else
				code = REQ_UNUSED;
			// The pattern is drawn from empty, full, one-hot, one-cold or fully random words.
			bit_pos = $urandom_range(0, bops_pkg::PATTERN_W - 1);
			case ($urandom_range(0, 7))
				0:       pattern = '0;
				1:       pattern = '1;
				2:       pattern = bops_pkg::PATTERN_W'(1) << bit_pos;
				3:       pattern = ~(bops_pkg::PATTERN_W'(1) << bit_pos);
				default: pattern = bops_pkg::PATTERN_W'($urandom());
			endcase
			if ($urandom_range(0, 9) == 0)
				index = bops_pkg::STAT_INDEX_W'($urandom_range(TOTAL_INDEX + 1, 63));
			else
				index = bops_pkg::STAT_INDEX_W'($urandom_range(0, TOTAL_INDEX));
			send_request(code, pattern, index);
			if (pause_midway && n == items / 2)
				wait_for_drain();
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_sequence
		logic [63:0] wide;
		arst_n            <= 1'b0;
		cfg_wr_en         <= 1'b0;
		cfg_wr_data       <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= bops_pkg::REQ_COUNT;
		req_ch.pattern    <= '0;
		req_ch.stat_index <= '0;
		clear_histogram();
		limit_setting = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_requests();
		test_sample_limit_edges();

		wide = {$urandom(), $urandom()};
		test_random_traffic('0, 250, 3, 1'b1, 1'b1, 1'b0);
		test_random_traffic(bops_pkg::LIMIT_W'($urandom_range(1, 8)), 250, 6,
			1'b0, 1'b1, 1'b0);
		test_random_traffic(bops_pkg::LIMIT_W'($urandom_range(9, 40)), 250, 2,
			1'b1, 1'b0, 1'b0);
		test_random_traffic('1, 150, 3, 1'b0, 1'b0, 1'b0);
		test_random_traffic(wide[bops_pkg::LIMIT_W-1:0], 150, 3, 1'b1, 1'b1, 1'b0);
		test_random_traffic(48'd3, 250, 5, 1'b1, 1'b1, 1'b1);

		wait_for_drain();
		if (mismatches == 0)
			$display("bit_occupancy_popcount_stats regression: pass");
		else
			$display("bit_occupancy_popcount_stats regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/bops_pkg.sv
hw/rtl/bops_req_if.sv
hw/rtl/bops_rsp_if.sv
hw/rtl/bit_occupancy_popcount_stats.sv
tb/bit_occupancy_popcount_stats_test.sv
